### rtl/fcst_pkg.sv
// ----------------------------------------------------------------------------
// fcst_pkg: shared definitions for the floor and ceiling span texturer
// Texture geometry, address widths, opcodes and the command format that
// travels from the front end through the queue to the texel back end.
// ----------------------------------------------------------------------------
package fcst_pkg;

    // Texture geometry: two square textures of TEX_SIZE x TEX_SIZE texels.
    localparam int TEX_SIZE    = 64;
    localparam int TEX_COORD_W = $clog2(TEX_SIZE);
    localparam int TEX_ADDR_W  = 12;
    localparam int TEX_WORDS   = 1 << TEX_ADDR_W;
    localparam int TEX_PROD_W  = 16 + TEX_COORD_W;

    // Screen side widths.
    localparam int ADDR_W  = 24;
    localparam int CNT_W   = 13;
    localparam int ROW_W   = 12;
    localparam int POS_W   = 32;
    localparam int COLOR_W = 32;

    // Register reset values.
    localparam logic [CNT_W-1:0] WIDTH_RESET  = 13'd640;
    localparam logic [CNT_W-1:0] HEIGHT_RESET = 13'd480;

    // Configuration register byte addresses.
    localparam int PADDR_W = 3;
    localparam logic [PADDR_W-1:0] REG_WIDTH_ADDR  = 3'd0;
    localparam logic [PADDR_W-1:0] REG_HEIGHT_ADDR = 3'd4;

    // Command queue between front end and back end.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Input item opcodes; the fourth code is unused and ignored.
    typedef enum logic [1:0] {
        OP_WRITE_TEXEL = 2'd0,
        OP_START_ROW   = 2'd1,
        OP_NEXT_PIXEL  = 2'd2
    } t_opcode;

    // One queued command: a texel write or a pixel to be textured.
    typedef struct packed {
        logic                   is_pixel;
        logic                   tex_sel;
        logic [TEX_ADDR_W-1:0]  tex_index;
        logic [COLOR_W-1:0]     texel_value;
        logic [TEX_COORD_W-1:0] tex_x;
        logic [TEX_COORD_W-1:0] tex_y;
        logic [ADDR_W-1:0]      floor_addr;
        logic [ADDR_W-1:0]      ceil_addr;
    } t_cmd;

    // Texture coordinate from the floor-wise fraction of a Q16.16 position.
    function automatic logic [TEX_COORD_W-1:0] tex_coord(input logic [POS_W-1:0] pos);
        logic [TEX_PROD_W-1:0] prod;
        prod = TEX_PROD_W'(pos[15:0]) * TEX_PROD_W'(TEX_SIZE);
        return prod[TEX_PROD_W-1:16];
    endfunction

endpackage

### rtl/floor_ceiling_span_texturer_unit.sv
// ----------------------------------------------------------------------------
// floor_ceiling_span_texturer_unit: raycaster floor and ceiling span texturer
// Top level with the register port, the front end, the command queue and
// the texel back end.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): texel writes load the floor or ceiling texture,
//   a start-row item sets the row, start position and steps, and each pixel
//   item yields two output transfers: the floor write, then the mirrored
//   ceiling write marked by m_axis_tlast. Pixel items past the row end and
//   unused opcodes give nothing.
//   Register port: screen_width at address 0, screen_height at address 4;
//   write them only while the block is idle.
//   Path: a pixel goes through the command queue, the memory stage and the
//   output stage, which sends its floor transfer first.
//   Writes and start items put nothing on the output; a pixel puts two
//   transfers on the single output channel.
//   A four-entry command queue decouples input from the back end, so input
//   keeps flowing while a result waits.
//   Reset (synchronous, active low) restores 640 x 480, idles the span and
//   empties the queue; texture contents are undefined until written.
//   When the receiver stalls, the output holds and the queue fills; then
//   s_axis_tready drops until room frees up.
// ----------------------------------------------------------------------------
module floor_ceiling_span_texturer_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Input stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: texel_index[11:0], texel_value[43:12], row_index[55:44],
    //        start_x[87:56], start_y[119:88], delta_x[151:120], delta_y[183:152]
    input  logic [183:0]                       s_axis_tdata,
    // tuser: opcode[1:0], texture_select[2]
    input  logic [2:0]                         s_axis_tuser,
    // Output stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: pixel_address[23:0], pixel_color[55:24]
    output logic [55:0]                        m_axis_tdata,
    output logic                               m_axis_tlast,
    // Register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [fcst_pkg::PADDR_W-1:0]       paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    logic [fcst_pkg::CNT_W-1:0] r_screen_width;
    logic [fcst_pkg::CNT_W-1:0] r_screen_height;

    logic                            queue_full;
    logic                            push;
    fcst_pkg::t_cmd                  push_cmd;
    logic                            head_valid;
    fcst_pkg::t_cmd                  head;
    logic                            pop;
    logic [fcst_pkg::ADDR_W-1:0]     pixel_address;
    logic [fcst_pkg::COLOR_W-1:0]    pixel_color;

    // Register writes complete in the access cycle.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_width  <= fcst_pkg::WIDTH_RESET;
            r_screen_height <= fcst_pkg::HEIGHT_RESET;
        end else if (psel && penable && pwrite) begin
            unique case (paddr)
                fcst_pkg::REG_WIDTH_ADDR:  r_screen_width  <= pwdata[fcst_pkg::CNT_W-1:0];
                fcst_pkg::REG_HEIGHT_ADDR: r_screen_height <= pwdata[fcst_pkg::CNT_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register read-back.
    always_comb begin
        unique case (paddr)
            fcst_pkg::REG_WIDTH_ADDR:  prdata = 32'(r_screen_width);
            fcst_pkg::REG_HEIGHT_ADDR: prdata = 32'(r_screen_height);
            default:                   prdata = '0;
        endcase
    end

    fcst_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (s_axis_tvalid),
        .o_ready          (s_axis_tready),
        .i_opcode         (s_axis_tuser[1:0]),
        .i_texture_select (s_axis_tuser[2]),
        .i_texel_index    (s_axis_tdata[11:0]),
        .i_texel_value    (s_axis_tdata[43:12]),
        .i_row_index      (s_axis_tdata[55:44]),
        .i_start_x        (s_axis_tdata[87:56]),
        .i_start_y        (s_axis_tdata[119:88]),
        .i_delta_x        (s_axis_tdata[151:120]),
        .i_delta_y        (s_axis_tdata[183:152]),
        .i_screen_width   (r_screen_width),
        .i_screen_height  (r_screen_height),
        .i_queue_full     (queue_full),
        .o_push           (push),
        .o_cmd            (push_cmd)
    );

    fcst_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (push_cmd),
        .o_full       (queue_full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    fcst_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head_valid    (head_valid),
        .i_head          (head),
        .o_pop           (pop),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_pixel_address (pixel_address),
        .o_pixel_color   (pixel_color),
        .o_last          (m_axis_tlast)
    );

    assign m_axis_tdata = {pixel_color, pixel_address};

endmodule

### rtl/fcst_front.sv
// ----------------------------------------------------------------------------
// fcst_front: span front end
// Accepts input items, keeps the span state (position, steps, column and row
// bases) and turns texel writes and live pixels into queued commands.
// ----------------------------------------------------------------------------
module fcst_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic [1:0]                        i_opcode,
    input  logic                              i_texture_select,
    input  logic [fcst_pkg::TEX_ADDR_W-1:0]   i_texel_index,
    input  logic [fcst_pkg::COLOR_W-1:0]      i_texel_value,
    input  logic [fcst_pkg::ROW_W-1:0]        i_row_index,
    input  logic signed [fcst_pkg::POS_W-1:0] i_start_x,
    input  logic signed [fcst_pkg::POS_W-1:0] i_start_y,
    input  logic signed [fcst_pkg::POS_W-1:0] i_delta_x,
    input  logic signed [fcst_pkg::POS_W-1:0] i_delta_y,
    input  logic [fcst_pkg::CNT_W-1:0]        i_screen_width,
    input  logic [fcst_pkg::CNT_W-1:0]        i_screen_height,
    input  logic                              i_queue_full,
    output logic                              o_push,
    output fcst_pkg::t_cmd                    o_cmd
);

    logic [fcst_pkg::POS_W-1:0]  r_pos_x, n_pos_x;
    logic [fcst_pkg::POS_W-1:0]  r_pos_y, n_pos_y;
    logic [fcst_pkg::POS_W-1:0]  r_inc_x, n_inc_x;
    logic [fcst_pkg::POS_W-1:0]  r_inc_y, n_inc_y;
    logic [fcst_pkg::CNT_W-1:0]  r_col, n_col;
    logic [fcst_pkg::ADDR_W-1:0] r_floor_base, n_floor_base;
    logic [fcst_pkg::ADDR_W-1:0] r_ceil_base, n_ceil_base;

    logic                        accept;
    logic                        pixel_live;
    logic [fcst_pkg::ADDR_W-1:0] width_ext;
    logic [fcst_pkg::ADDR_W-1:0] mirror_row;

    // The front end takes an item whenever the queue has room.
    assign o_ready    = !i_queue_full;
    assign accept     = i_valid && o_ready;
    assign pixel_live = r_col < i_screen_width;
    assign width_ext  = fcst_pkg::ADDR_W'(i_screen_width);
    assign mirror_row = fcst_pkg::ADDR_W'(i_screen_height) - fcst_pkg::ADDR_W'(i_row_index)
                        - fcst_pkg::ADDR_W'(1);

    // Command build and span state update.
    always_comb begin
        n_pos_x      = r_pos_x;
        n_pos_y      = r_pos_y;
        n_inc_x      = r_inc_x;
        n_inc_y      = r_inc_y;
        n_col        = r_col;
        n_floor_base = r_floor_base;
        n_ceil_base  = r_ceil_base;
        o_push       = 1'b0;

        o_cmd.is_pixel    = 1'b0;
        o_cmd.tex_sel     = i_texture_select;
        o_cmd.tex_index   = i_texel_index;
        o_cmd.texel_value = i_texel_value;
        o_cmd.tex_x       = fcst_pkg::tex_coord(r_pos_x);
        o_cmd.tex_y       = fcst_pkg::tex_coord(r_pos_y);
        o_cmd.floor_addr  = r_floor_base + fcst_pkg::ADDR_W'(r_col);
        o_cmd.ceil_addr   = r_ceil_base + fcst_pkg::ADDR_W'(r_col);

        if (accept) begin
            unique case (i_opcode)
                fcst_pkg::OP_WRITE_TEXEL: begin
                    o_push = 1'b1;
                end
                fcst_pkg::OP_START_ROW: begin
                    n_floor_base = fcst_pkg::ADDR_W'(i_row_index) * width_ext;
                    n_ceil_base  = mirror_row * width_ext;
                    n_pos_x      = i_start_x;
                    n_pos_y      = i_start_y;
                    n_inc_x      = i_delta_x;
                    n_inc_y      = i_delta_y;
                    n_col        = '0;
                end
                fcst_pkg::OP_NEXT_PIXEL: begin
                    if (pixel_live) begin
                        o_push         = 1'b1;
                        o_cmd.is_pixel = 1'b1;
                        n_pos_x        = r_pos_x + r_inc_x;
                        n_pos_y        = r_pos_y + r_inc_y;
                        n_col          = r_col + fcst_pkg::CNT_W'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Span state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_inc_x      <= '0;
            r_inc_y      <= '0;
            r_col        <= fcst_pkg::WIDTH_RESET;
            r_floor_base <= '0;
            r_ceil_base  <= '0;
        end else begin
            r_pos_x      <= n_pos_x;
            r_pos_y      <= n_pos_y;
            r_inc_x      <= n_inc_x;
            r_inc_y      <= n_inc_y;
            r_col        <= n_col;
            r_floor_base <= n_floor_base;
            r_ceil_base  <= n_ceil_base;
        end
    end

endmodule

### rtl/fcst_queue.sv
// ----------------------------------------------------------------------------
// fcst_queue: command queue
// A short first-in first-out queue of commands that lets the front end run
// ahead of the texel back end.
// ----------------------------------------------------------------------------
module fcst_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fcst_pkg::t_cmd i_cmd,
    output logic           o_full,
    output logic           o_head_valid,
    output fcst_pkg::t_cmd o_head,
    input  logic           i_pop
);

    fcst_pkg::t_cmd r_slots [fcst_pkg::QUEUE_DEPTH];

    logic [fcst_pkg::QPTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [fcst_pkg::QPTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [fcst_pkg::QCNT_W-1:0] r_count, n_count;

    assign o_full       = r_count == fcst_pkg::QCNT_W'(fcst_pkg::QUEUE_DEPTH);
    assign o_head_valid = r_count != '0;
    assign o_head       = r_slots[r_rd_ptr];

    // Pointer and fill count update.
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == fcst_pkg::QPTR_W'(fcst_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + fcst_pkg::QPTR_W'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == fcst_pkg::QPTR_W'(fcst_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + fcst_pkg::QPTR_W'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + fcst_pkg::QCNT_W'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - fcst_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Slot storage needs no reset.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_cmd;
        end
    end

    // A push lands on a full queue only together with a pop, and a pop never on an empty one.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_head_valid)
        else $error("command popped from an empty queue");

endmodule

### rtl/fcst_back.sv
// ----------------------------------------------------------------------------
// fcst_back: texel back end
// Holds the floor and ceiling textures, carries out texel writes, fetches
// both texels of a pixel and sends the floor and ceiling screen writes.
// ----------------------------------------------------------------------------
module fcst_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_head_valid,
    input  fcst_pkg::t_cmd                   i_head,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic [fcst_pkg::ADDR_W-1:0]      o_pixel_address,
    output logic [fcst_pkg::COLOR_W-1:0]     o_pixel_color,
    output logic                             o_last
);

    // Memory stage contents.
    typedef struct packed {
        logic                              is_pixel;
        logic                              tex_sel;
        logic [fcst_pkg::TEX_ADDR_W-1:0]   tex_addr;
        logic [fcst_pkg::COLOR_W-1:0]      texel_value;
        logic [fcst_pkg::ADDR_W-1:0]       floor_addr;
        logic [fcst_pkg::ADDR_W-1:0]       ceil_addr;
    } t_mem_stage;

    logic [fcst_pkg::COLOR_W-1:0] r_floor_mem [fcst_pkg::TEX_WORDS];
    logic [fcst_pkg::COLOR_W-1:0] r_ceil_mem  [fcst_pkg::TEX_WORDS];

    logic                          r_s1_valid, n_s1_valid;
    t_mem_stage                    r_s1, n_s1;
    logic                          r_s2_valid, n_s2_valid;
    logic                          r_phase, n_phase;
    logic [fcst_pkg::ADDR_W-1:0]   r_floor_addr;
    logic [fcst_pkg::ADDR_W-1:0]   r_ceil_addr;
    logic [fcst_pkg::COLOR_W-1:0]  r_floor_texel;
    logic [fcst_pkg::COLOR_W-1:0]  r_ceil_texel;

    logic s2_free;
    logic s1_adv;
    logic s1_ready;
    logic s2_load;

    // Halve red, green and blue and move alpha to the top byte.
    function automatic logic [fcst_pkg::COLOR_W-1:0] shade(
        input logic [fcst_pkg::COLOR_W-1:0] p
    );
        return {p[7:0], 1'b0, p[31:25], 1'b0, p[23:17], 1'b0, p[15:9]};
    endfunction

    // Stage handoff: the output stage holds a pixel for its two transfers.
    assign s2_free  = !r_s2_valid || (r_phase && i_ready);
    assign s1_adv   = r_s1_valid && (!r_s1.is_pixel || s2_free);
    assign s1_ready = !r_s1_valid || s1_adv;
    assign o_pop    = i_head_valid && s1_ready;
    assign s2_load  = s1_adv && r_s1.is_pixel;

    // Memory stage load, with the texel address worked out from the coordinates.
    always_comb begin
        n_s1_valid = r_s1_valid;
        n_s1       = r_s1;
        if (o_pop) begin
            n_s1_valid       = 1'b1;
            n_s1.is_pixel    = i_head.is_pixel;
            n_s1.tex_sel     = i_head.tex_sel;
            n_s1.texel_value = i_head.texel_value;
            n_s1.floor_addr  = i_head.floor_addr;
            n_s1.ceil_addr   = i_head.ceil_addr;
            n_s1.tex_addr    = i_head.is_pixel ?
                fcst_pkg::TEX_ADDR_W'(i_head.tex_y) * fcst_pkg::TEX_ADDR_W'(fcst_pkg::TEX_SIZE)
                + fcst_pkg::TEX_ADDR_W'(i_head.tex_x) : i_head.tex_index;
        end else if (s1_adv) begin
            n_s1_valid = 1'b0;
        end
    end

    // Output stage: floor transfer first, then the ceiling transfer.
    always_comb begin
        n_s2_valid = r_s2_valid;
        n_phase    = r_phase;
        if (s2_load) begin
            n_s2_valid = 1'b1;
            n_phase    = 1'b0;
        end else if (r_s2_valid && i_ready) begin
            if (r_phase) begin
                n_s2_valid = 1'b0;
            end else begin
                n_phase = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_phase    <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
            r_s2_valid <= n_s2_valid;
            r_phase    <= n_phase;
        end
    end

    // Stage payload.
    always_ff @(posedge i_clk) begin
        r_s1 <= n_s1;
        if (s2_load) begin
            r_floor_addr <= r_s1.floor_addr;
            r_ceil_addr  <= r_s1.ceil_addr;
        end
    end

    // Texture memories: one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (s1_adv && !r_s1.is_pixel && !r_s1.tex_sel) begin
            r_floor_mem[r_s1.tex_addr] <= r_s1.texel_value;
        end
        if (s2_load) begin
            r_floor_texel <= r_floor_mem[r_s1.tex_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && !r_s1.is_pixel && r_s1.tex_sel) begin
            r_ceil_mem[r_s1.tex_addr] <= r_s1.texel_value;
        end
        if (s2_load) begin
            r_ceil_texel <= r_ceil_mem[r_s1.tex_addr];
        end
    end

    assign o_valid         = r_s2_valid;
    assign o_last          = r_phase;
    assign o_pixel_address = r_phase ? r_ceil_addr : r_floor_addr;
    assign o_pixel_color   = r_phase ? shade(r_ceil_texel) : shade(r_floor_texel);

    // The ceiling transfer always follows an accepted floor transfer.
    a_ceiling_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !r_phase && i_ready |=> r_s2_valid && r_phase)
        else $error("ceiling transfer did not follow the floor transfer");

    // A pixel never enters the output stage while the pixel there waits on its floor transfer.
    a_no_pixel_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && !r_phase |-> !s2_load)
        else $error("pixel overwrote a pending floor transfer");

    // A finished pixel with nothing behind it leaves the output stage empty.
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_valid && r_phase && i_ready && !s2_load |=> !r_s2_valid)
        else $error("output stage kept a finished pixel");

endmodule

### verif/floor_ceiling_span_texturer_unit_tb.sv
// ----------------------------------------------------------------------------
// floor_ceiling_span_texturer_unit_tb: self-checking bench for the span texturer
// Loads floor and ceiling texels, starts rows and steps pixels over several
// screen sizes. A cycle-free predictor computes the screen writes that each
// accepted input transfer causes, and the output monitor compares every
// output transfer with the oldest predicted write. Both stream sides idle
// at random, and one long receiver stall makes the block back up its input.
// ----------------------------------------------------------------------------
module floor_ceiling_span_texturer_unit_tb;

    // Opcode that the block ignores.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Cycles to settle after the last expected write; covers the pipeline.
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    localparam int ITEMS_PER_PHASE = 105;

    typedef struct {
        logic [1:0]                      opcode;
        logic                            tex_sel;
        logic [fcst_pkg::TEX_ADDR_W-1:0] texel_index;
        logic [fcst_pkg::COLOR_W-1:0]    texel_value;
        logic [fcst_pkg::ROW_W-1:0]      row;
        logic [fcst_pkg::POS_W-1:0]      start_x;
        logic [fcst_pkg::POS_W-1:0]      start_y;
        logic [fcst_pkg::POS_W-1:0]      delta_x;
        logic [fcst_pkg::POS_W-1:0]      delta_y;
    } t_span_item;

    typedef struct {
        logic [fcst_pkg::ADDR_W-1:0]  address;
        logic [fcst_pkg::COLOR_W-1:0] color;
        logic                         ceiling;
    } t_screen_write;

    // DUT connections; the driven inputs are known from time zero.
    logic                         i_clk = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [183:0]                 s_axis_tdata = '0;
    logic [2:0]                   s_axis_tuser = '0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [55:0]                  m_axis_tdata;
    logic                         m_axis_tlast;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [fcst_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    floor_ceiling_span_texturer_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Predictor state: registers, textures and the current span.
    logic [fcst_pkg::CNT_W-1:0]   cfg_width = fcst_pkg::WIDTH_RESET;
    logic [fcst_pkg::CNT_W-1:0]   cfg_height = fcst_pkg::HEIGHT_RESET;
    logic [fcst_pkg::COLOR_W-1:0] tex_mem [2][fcst_pkg::TEX_WORDS];
    logic [fcst_pkg::POS_W-1:0]   span_pos_x = '0;
    logic [fcst_pkg::POS_W-1:0]   span_pos_y = '0;
    logic [fcst_pkg::POS_W-1:0]   span_step_x = '0;
    logic [fcst_pkg::POS_W-1:0]   span_step_y = '0;
    logic [fcst_pkg::CNT_W-1:0]   span_col = fcst_pkg::WIDTH_RESET;
    logic [fcst_pkg::ADDR_W-1:0]  floor_base = '0;
    logic [fcst_pkg::ADDR_W-1:0]  ceiling_base = '0;

    // Stimulus-side tracking, so that no pixel reads an unloaded texel.
    bit                           texel_loaded [2][fcst_pkg::TEX_WORDS];
    logic [fcst_pkg::POS_W-1:0]   gen_pos_x = '0;
    logic [fcst_pkg::POS_W-1:0]   gen_pos_y = '0;
    logic [fcst_pkg::POS_W-1:0]   gen_step_x = '0;
    logic [fcst_pkg::POS_W-1:0]   gen_step_y = '0;
    int                           gen_col = fcst_pkg::WIDTH_RESET;
    int                           items_queued = 0;

    t_span_item                   span_items[$];
    t_screen_write                screen_writes_due[$];
    t_span_item                   on_bus;
    t_screen_write                oldest_due;

    int                           error_count = 0;
    int                           send_gap = 0;
    int                           ready_gap = 0;
    int                           long_hold_left = 0;
    bit                           idle_on = 1'b1;

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Fail-safe limit on the whole run.
    initial begin
        #2000000;
        $display("floor_ceiling_span_texturer_unit_tb failed");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got 0x%08h, expected 0x%08h at %0t", what, got, want, $time);
        error_count++;
    endtask

    // Texel address from the texture coordinates of the floor-wise Q16.16 fractions.
    function automatic logic [fcst_pkg::TEX_ADDR_W-1:0] texel_addr(
        input logic [fcst_pkg::POS_W-1:0] px,
        input logic [fcst_pkg::POS_W-1:0] py
    );
        logic [31:0] tx;
        logic [31:0] ty;
        tx = ({16'b0, px[15:0]} * fcst_pkg::TEX_SIZE) >> 16;
        ty = ({16'b0, py[15:0]} * fcst_pkg::TEX_SIZE) >> 16;
        return fcst_pkg::TEX_ADDR_W'(ty * fcst_pkg::TEX_SIZE + tx);
    endfunction

    // RGBA texel to ARGB with the color channels halved.
    function automatic logic [fcst_pkg::COLOR_W-1:0] halve_rgb(
        input logic [fcst_pkg::COLOR_W-1:0] p
    );
        return {p[7:0], p[31:24] >> 1, p[23:16] >> 1, p[15:8] >> 1};
    endfunction

    // Predicted effect of one accepted input transfer.
    function automatic void step_texturer(input t_span_item it);
        logic [31:0]                     mirror_row;
        logic [fcst_pkg::TEX_ADDR_W-1:0] taddr;
        t_screen_write                   w;
        case (it.opcode)
            fcst_pkg::OP_WRITE_TEXEL: begin
                tex_mem[it.tex_sel][it.texel_index] = it.texel_value;
            end
            fcst_pkg::OP_START_ROW: begin
                mirror_row   = 32'(cfg_height) - 32'(it.row) - 32'd1;
                floor_base   = fcst_pkg::ADDR_W'(32'(it.row) * 32'(cfg_width));
                ceiling_base = fcst_pkg::ADDR_W'(mirror_row * 32'(cfg_width));
                span_pos_x   = it.start_x;
                span_pos_y   = it.start_y;
                span_step_x  = it.delta_x;
                span_step_y  = it.delta_y;
                span_col     = '0;
            end
            fcst_pkg::OP_NEXT_PIXEL: begin
                if (span_col < cfg_width) begin
                    taddr = texel_addr(span_pos_x, span_pos_y);
                    w.address = floor_base + fcst_pkg::ADDR_W'(span_col);
                    w.color   = halve_rgb(tex_mem[0][taddr]);
                    w.ceiling = 1'b0;
                    screen_writes_due.push_back(w);
                    w.address = ceiling_base + fcst_pkg::ADDR_W'(span_col);
                    w.color   = halve_rgb(tex_mem[1][taddr]);
                    w.ceiling = 1'b1;
                    screen_writes_due.push_back(w);
                    span_pos_x = span_pos_x + span_step_x;
                    span_pos_y = span_pos_y + span_step_y;
                    span_col   = span_col + fcst_pkg::CNT_W'(1);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // An item with every field random; each builder overrides what it uses.
    function automatic t_span_item random_item();
        t_span_item it;
        it.opcode      = 2'($urandom_range(0, 3));
        it.tex_sel     = 1'($urandom_range(0, 1));
        it.texel_index = fcst_pkg::TEX_ADDR_W'($urandom());
        it.texel_value = $urandom();
        it.row         = fcst_pkg::ROW_W'($urandom());
        it.start_x     = $urandom();
        it.start_y     = $urandom();
        it.delta_x     = $urandom();
        it.delta_y     = $urandom();
        return it;
    endfunction

    // Either a full-range Q16.16 value or a small signed one.
    function automatic logic [fcst_pkg::POS_W-1:0] random_q16();
        logic [17:0] mag;
        mag = 18'($urandom());
        if ($urandom_range(0, 1) == 0) begin
            return $urandom();
        end
        return {{14{mag[17]}}, mag};
    endfunction

    function automatic void push_write(input logic sel,
                                       input logic [fcst_pkg::TEX_ADDR_W-1:0] idx,
                                       input logic [fcst_pkg::COLOR_W-1:0] value);
        t_span_item it;
        it = random_item();
        it.opcode      = fcst_pkg::OP_WRITE_TEXEL;
        it.tex_sel     = sel;
        it.texel_index = idx;
        it.texel_value = value;
        texel_loaded[sel][idx] = 1'b1;
        span_items.push_back(it);
        items_queued++;
    endfunction

    function automatic void push_start(input logic [fcst_pkg::ROW_W-1:0] row,
                                       input logic [fcst_pkg::POS_W-1:0] sx,
                                       input logic [fcst_pkg::POS_W-1:0] sy,
                                       input logic [fcst_pkg::POS_W-1:0] dx,
                                       input logic [fcst_pkg::POS_W-1:0] dy);
        t_span_item it;
        it = random_item();
        it.opcode  = fcst_pkg::OP_START_ROW;
        it.row     = row;
        it.start_x = sx;
        it.start_y = sy;
        it.delta_x = dx;
        it.delta_y = dy;
        gen_pos_x  = sx;
        gen_pos_y  = sy;
        gen_step_x = dx;
        gen_step_y = dy;
        gen_col    = 0;
        span_items.push_back(it);
        items_queued++;
    endfunction

    // A pixel; loads the texels it will read first if they are still empty.
    function automatic void push_pixel();
        t_span_item                      it;
        logic [fcst_pkg::TEX_ADDR_W-1:0] a;
        it = random_item();
        it.opcode = fcst_pkg::OP_NEXT_PIXEL;
        if (gen_col < cfg_width) begin
            a = texel_addr(gen_pos_x, gen_pos_y);
            for (int s = 0; s < 2; s++) begin
                if (!texel_loaded[s][a]) begin
                    push_write(1'(s), a, $urandom());
                end
            end
            gen_pos_x = gen_pos_x + gen_step_x;
            gen_pos_y = gen_pos_y + gen_step_y;
            gen_col++;
            items_queued++;
        end
        span_items.push_back(it);
    endfunction

    function automatic void push_unused();
        t_span_item it;
        it = random_item();
        it.opcode = OP_UNUSED;
        span_items.push_back(it);
    endfunction

    // Short directed opening at the reset screen size.
    function automatic void fill_directed();
        push_pixel();
        push_unused();
        push_write(1'b0, 12'd0, 32'hFFFFFFFF);
        push_write(1'b1, 12'd0, 32'h00000000);
        push_write(1'b0, 12'd4095, 32'h80808080);
        push_write(1'b1, 12'd4095, 32'h01FE01FE);
        push_start(12'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        push_pixel();
        push_pixel();
        // Row below the screen, so the mirrored row goes negative; the
        // position wraps past the signed range on the first step.
        push_start(12'd4095, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        push_pixel();
        push_pixel();
        push_pixel();
        // A negative step walks the y fraction downward from its top value.
        push_start(12'd479, 32'h80000000, 32'h0000FFFF, 32'h00000400, 32'hFFFFFC00);
        push_pixel();
        push_pixel();
        push_pixel();
        push_start(12'd240, 32'hFFFF8000, 32'h00010000, 32'hFFFFF000, 32'h00001000);
        push_pixel();
        push_pixel();
        push_unused();
    endfunction

    // Mostly new spans of random length and content, with loose writes and noise.
    function automatic void fill_random(input int n);
        int target;
        int pick;
        int run;
        int row_max;
        target  = items_queued + n;
        row_max = (cfg_height > 4095) ? 4095 : int'(cfg_height) - 1;
        // Pixels before any new start continue the old span or run past its end.
        run = $urandom_range(1, 3);
        for (int k = 0; k < run; k++) begin
            push_pixel();
        end
        while (items_queued < target) begin
            pick = $urandom_range(0, 19);
            if (pick < 2) begin
                push_write(1'($urandom_range(0, 1)), fcst_pkg::TEX_ADDR_W'($urandom()),
                           $urandom());
            end else if (pick == 2) begin
                push_unused();
            end else if (pick < 18) begin
                push_start(($urandom_range(0, 3) == 0) ?
                               fcst_pkg::ROW_W'($urandom()) :
                               fcst_pkg::ROW_W'($urandom_range(0, row_max)),
                           $urandom(), $urandom(), random_q16(), random_q16());
                run = $urandom_range(1, (cfg_width + 1 > 14) ? 14 : int'(cfg_width) + 1);
                for (int k = 0; k < run; k++) begin
                    push_pixel();
                end
            end else begin
                push_pixel();
            end
        end
    endfunction

    // Register access: setup cycle, then access cycle.
    task automatic reg_write(input logic [fcst_pkg::PADDR_W-1:0] addr,
                             input logic [31:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == fcst_pkg::REG_WIDTH_ADDR) begin
            cfg_width = value[fcst_pkg::CNT_W-1:0];
        end else begin
            cfg_height = value[fcst_pkg::CNT_W-1:0];
        end
    endtask

    task automatic reg_check(input logic [fcst_pkg::PADDR_W-1:0] addr,
                             input logic [fcst_pkg::CNT_W-1:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== 32'(want)) begin
            report_mismatch("register read", prdata, 32'(want));
        end
    endtask

    task automatic set_screen(input int width, input int height);
        reg_write(fcst_pkg::REG_WIDTH_ADDR, 32'(width));
        reg_write(fcst_pkg::REG_HEIGHT_ADDR, 32'(height));
        reg_check(fcst_pkg::REG_WIDTH_ADDR, cfg_width);
        reg_check(fcst_pkg::REG_HEIGHT_ADDR, cfg_height);
    endtask

    // Wait until every item is sent and every predicted write has come out.
    task automatic drain();
        while (span_items.size() != 0 || s_axis_tvalid || screen_writes_due.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Input driver: predicts each accepted transfer, then offers the next one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                step_texturer(on_bus);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (span_items.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    send_gap = $urandom_range(1, 4) - 1;
                    s_axis_tvalid <= 1'b0;
                end else begin
                    on_bus = span_items.pop_front();
                    s_axis_tdata <= {on_bus.delta_y, on_bus.delta_x, on_bus.start_y,
                                     on_bus.start_x, on_bus.row, on_bus.texel_value,
                                     on_bus.texel_index};
                    s_axis_tuser <= {on_bus.tex_sel, on_bus.opcode};
                    s_axis_tvalid <= 1'b1;
                end
            end
        end
    end

    // Long receiver hold-off, counted down here.
    always @(posedge i_clk) begin
        if (long_hold_left > 0) begin
            long_hold_left <= long_hold_left - 1;
        end
    end

    // Output monitor: checks each transfer against the oldest predicted write.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (screen_writes_due.size() == 0) begin
                    report_mismatch("unexpected screen write", 32'(m_axis_tdata[23:0]), '0);
                end else begin
                    oldest_due = screen_writes_due.pop_front();
                    if (m_axis_tdata[23:0] !== oldest_due.address) begin
                        report_mismatch("pixel address", 32'(m_axis_tdata[23:0]),
                                        32'(oldest_due.address));
                    end
                    if (m_axis_tdata[55:24] !== oldest_due.color) begin
                        report_mismatch("pixel color", m_axis_tdata[55:24], oldest_due.color);
                    end
                    if (m_axis_tlast !== oldest_due.ceiling) begin
                        report_mismatch("ceiling flag", 32'(m_axis_tlast),
                                        32'(oldest_due.ceiling));
                    end
                end
            end
            if (long_hold_left > 0) begin
                m_axis_tready <= 1'b0;
            end else if (ready_gap > 0) begin
                ready_gap--;
                m_axis_tready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                ready_gap = $urandom_range(1, 4) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Test sequence: reset, directed opening, then phases over screen sizes.
    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        reg_check(fcst_pkg::REG_WIDTH_ADDR, fcst_pkg::WIDTH_RESET);
        reg_check(fcst_pkg::REG_HEIGHT_ADDR, fcst_pkg::HEIGHT_RESET);

        @(negedge i_clk);
        fill_directed();
        fill_random(ITEMS_PER_PHASE);
        drain();

        // Smallest screen: one pixel per row, and any row past the first mirrors to a negative row.
        set_screen(1, 1);
        @(negedge i_clk);
        fill_random(ITEMS_PER_PHASE);
        drain();

        // Largest screen, with the receiver holding off to back up the input.
        set_screen(4096, 4096);
        @(negedge i_clk);
        fill_random(ITEMS_PER_PHASE);
        long_hold_left = LONG_HOLD;
        drain();

        // Narrow rows, so spans run past their end often.
        set_screen(3, $urandom_range(1, 4096));
        @(negedge i_clk);
        fill_random(ITEMS_PER_PHASE);
        drain();

        // Widened screen lets the old span run on; no idling in this part.
        set_screen($urandom_range(100, 4096), $urandom_range(1, 4096));
        @(negedge i_clk);
        idle_on = 1'b0;
        fill_random(ITEMS_PER_PHASE);
        drain();

        if (error_count == 0) begin
            $display("floor_ceiling_span_texturer_unit_tb passed");
        end else begin
            $display("floor_ceiling_span_texturer_unit_tb failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/fcst_pkg.sv
rtl/fcst_front.sv
rtl/fcst_queue.sv
rtl/fcst_back.sv
rtl/floor_ceiling_span_texturer_unit.sv
verif/floor_ceiling_span_texturer_unit_tb.sv
